### src/wfhp_pkg.sv
// wfhp_pkg: shared types and constants for the 802.11 frame header parser
// used by wifi_frame_header_parser and wfhp_out_fifo; no dependencies
package wfhp_pkg;

  // information element walk phases
  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  // ssid status codes
  localparam logic [1:0] SSID_NONE    = 2'd0;
  localparam logic [1:0] SSID_HIDDEN  = 2'd1;
  localparam logic [1:0] SSID_PRESENT = 2'd2;

  // receiver frame kinds and frame types
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] TYPE_MGMT  = 2'd0;

  // subtypes of interest
  localparam logic [3:0] SUBTYPE_PROBE_RESP = 4'h5;
  localparam logic [3:0] SUBTYPE_BEACON     = 4'h8;
  localparam logic [3:0] SUBTYPE_NULL       = 4'h4;
  localparam logic [3:0] SUBTYPE_QOS_NULL   = 4'hC;
  localparam logic [3:0] SUBTYPE_QOS_CFP    = 4'hE;
  localparam logic [3:0] SUBTYPE_QOS_CFACK  = 4'hF;

  // element walk start offsets and header layout
  localparam int unsigned IE_START_BEACON = 36;
  localparam int unsigned IE_START_OTHER  = 24;
  localparam int unsigned HDR_BASE        = 24;
  localparam int unsigned HDR_ADDR4       = 6;
  localparam int unsigned HDR_QOS         = 2;
  localparam int unsigned SNAP_SPAN       = 8;

  localparam logic [7:0] LLC_SAP     = 8'hAA;
  localparam logic [7:0] LLC_CTRL_UI = 8'h03;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_LOW    = 8'd32;
  localparam logic [7:0] CHAR_HIGH   = 8'd126;

  // snap header match progress
  localparam logic [2:0] SNAP_IDLE = 3'd0;
  localparam logic [2:0] SNAP_AA1  = 3'd1;
  localparam logic [2:0] SNAP_AA2  = 3'd2;
  localparam logic [2:0] SNAP_UI   = 3'd3;
  localparam logic [2:0] SNAP_ET1  = 3'd4;
  localparam logic [2:0] SNAP_DONE = 3'd5;

  // output queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

  typedef struct packed {
    logic        is_summary;
    logic        snap_found;
    logic [15:0] ethertype;
    logic [5:0]  ssid_length;
    logic [1:0]  ssid_status;
    logic        dest_bcast;
    logic [47:0] source_address;
    logic [47:0] destination_address;
    logic [3:0]  frame_subtype;
    logic [1:0]  frame_type;
    logic        discarded;
    logic [7:0]  ssid_char;
  } result_t;

endpackage

### src/wfhp_out_fifo.sv
// wfhp_out_fifo: small result queue, takes up to two results per cycle, gives one
// depends on wfhp_pkg (result_t, queue depth)
module wfhp_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  wfhp_pkg::result_t push_a,
  input  wfhp_pkg::result_t push_b,
  input  logic              pop,
  output logic              out_valid,
  output wfhp_pkg::result_t out_item,
  output logic              room_for_two
);

  localparam int unsigned PTR_W = wfhp_pkg::FIFO_PTR_W;

  wfhp_pkg::result_t mem [wfhp_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [PTR_W:0]    count;
  logic [PTR_W:0]    count_next;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wptr] <= push_a;
    end
    if (push_count == 2'd2) begin
      mem[wptr + PTR_W'(1)] <= push_b;
    end
  end

  always_comb begin
    count_next = count + (PTR_W+1)'(push_count) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push_count);
      rptr  <= rptr + PTR_W'(pop);
      count <= count_next;
    end
  end

  assign out_valid    = (count != '0);
  assign out_item     = mem[rptr];
  assign room_for_two = (count <= (PTR_W+1)'(wfhp_pkg::FIFO_DEPTH - 2));

endmodule

### src/wifi_frame_header_parser.sv
// wifi_frame_header_parser: 802.11 header, address and ssid extraction per byte
// results are written into the result queue at the byte's accepting edge
// throughput: one byte per cycle while ready is high; the parse logic sits between the byte port and
// a four-entry result queue, a last byte that also ends an ssid queues two results
// ready drops only while the queue holds more than two results
// reset (rst, synchronous) clears the parser state and empties the queue
module wifi_frame_header_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 4095,
  parameter int unsigned SSID_MAX_CHARS  = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,  // data_byte[7:0], frame_length[19:8], zero fill
  input  logic [1:0]   s_axis_tuser,  // frame_kind[1:0]
  input  logic         s_axis_tlast,  // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ssid_char[7:0], discarded[8], frame_type[10:9], frame_subtype[14:11],
  // destination_address[62:15], source_address[110:63], dest_bcast[111],
  // ssid_status[113:112], ssid_length[119:114], ethertype[135:120],
  // snap_found[136], zero fill
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tuser   // is_summary
);

  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned ES_W  = POS_W + 1;
  localparam int unsigned CNT_W = $clog2(SSID_MAX_CHARS + 1);
  localparam int unsigned CMP_W = ((POS_W > 12) ? POS_W : 12) + 2;

  logic [7:0]  data_byte;
  logic [11:0] frame_length;
  logic [1:0]  frame_kind;
  logic        last_byte;
  logic        accept;

  assign data_byte    = s_axis_tdata[7:0];
  assign frame_length = s_axis_tdata[19:8];
  assign frame_kind   = s_axis_tuser;
  assign last_byte    = s_axis_tlast;
  assign accept       = s_axis_tvalid & s_axis_tready;

  // parser state
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [15:0]       control_word, control_word_next;
  logic [47:0]       dest_shift, dest_shift_next;
  logic [47:0]       src_shift, src_shift_next;
  logic [ES_W-1:0]   element_start, element_start_next;
  logic [7:0]        element_tag, element_tag_next;
  logic [7:0]        element_remaining, element_remaining_next;
  wfhp_pkg::phase_t  walk_phase, walk_phase_next;
  logic [1:0]        ssid_state, ssid_state_next;
  logic [CNT_W-1:0]  ssid_count, ssid_count_next;
  logic [2:0]        snap_match, snap_match_next;
  logic [15:0]       ether_word, ether_word_next;
  logic              drop_flag, drop_flag_next;

  logic [CMP_W-1:0]  p_ext;
  logic [CMP_W-1:0]  flen_ext;
  logic [CMP_W-1:0]  hdr_len;
  logic [7:0]        rem_dec;
  logic [3:0]        sub_b;
  logic [15:0]       cw_hi;
  logic              emit;
  logic [7:0]        ch;
  logic              keep;
  logic              snap_ok;

  wfhp_pkg::result_t char_item;
  wfhp_pkg::result_t sum_item;
  wfhp_pkg::result_t push_a;
  wfhp_pkg::result_t push_b;
  logic [1:0]        push_count;
  wfhp_pkg::result_t out_item;
  logic              room_for_two;

  always_comb begin
    byte_position_next     = byte_position;
    control_word_next      = control_word;
    dest_shift_next        = dest_shift;
    src_shift_next         = src_shift;
    element_start_next     = element_start;
    element_tag_next       = element_tag;
    element_remaining_next = element_remaining;
    walk_phase_next        = walk_phase;
    ssid_state_next        = ssid_state;
    ssid_count_next        = ssid_count;
    snap_match_next        = snap_match;
    ether_word_next        = ether_word;
    drop_flag_next         = drop_flag;
    emit                   = 1'b0;
    ch                     = 8'd0;

    p_ext    = CMP_W'(byte_position);
    flen_ext = CMP_W'(frame_length);
    sub_b    = data_byte[7:4];
    cw_hi    = {data_byte, control_word[7:0]};
    rem_dec  = element_remaining - 8'((element_remaining != 8'd0) ? 1 : 0);
    hdr_len  = CMP_W'(wfhp_pkg::HDR_BASE)
             + ((control_word[9:8] == 2'b11) ? CMP_W'(wfhp_pkg::HDR_ADDR4) : '0)
             + (control_word[7] ? CMP_W'(wfhp_pkg::HDR_QOS) : '0);

    // frame control word
    if (byte_position == '0) begin
      control_word_next = {8'd0, data_byte};
      walk_phase_next   = wfhp_pkg::PH_TAG;
      if (data_byte[3:2] == wfhp_pkg::TYPE_MGMT &&
          (sub_b == wfhp_pkg::SUBTYPE_PROBE_RESP || sub_b == wfhp_pkg::SUBTYPE_BEACON) &&
          flen_ext > CMP_W'(wfhp_pkg::IE_START_BEACON)) begin
        element_start_next = ES_W'(wfhp_pkg::IE_START_BEACON);
      end else if (flen_ext > CMP_W'(wfhp_pkg::IE_START_OTHER)) begin
        element_start_next = ES_W'(wfhp_pkg::IE_START_OTHER);
      end else begin
        walk_phase_next = wfhp_pkg::PH_DONE;
      end
    end else if (byte_position == POS_W'(1)) begin
      control_word_next = cw_hi;
      if (cw_hi[14] ||
          (frame_kind == wfhp_pkg::KIND_DATA &&
           (cw_hi[7:4] == wfhp_pkg::SUBTYPE_NULL || cw_hi[7:4] == wfhp_pkg::SUBTYPE_QOS_NULL ||
            cw_hi[7:4] == wfhp_pkg::SUBTYPE_QOS_CFP ||
            cw_hi[7:4] == wfhp_pkg::SUBTYPE_QOS_CFACK))) begin
        drop_flag_next = 1'b1;
      end
    end

    // address capture, first byte ends up most significant
    if (p_ext >= CMP_W'(4) && p_ext <= CMP_W'(9)) begin
      dest_shift_next = {dest_shift[39:0], data_byte};
    end
    if (p_ext >= CMP_W'(10) && p_ext <= CMP_W'(15)) begin
      src_shift_next = {src_shift[39:0], data_byte};
    end

    if (p_ext >= CMP_W'(2) && !drop_flag) begin
      // information element walk
      unique case (walk_phase)
        wfhp_pkg::PH_TAG: begin
          if (p_ext == CMP_W'(element_start)) begin
            if (p_ext + CMP_W'(1) < flen_ext) begin
              element_tag_next = data_byte;
              walk_phase_next  = wfhp_pkg::PH_LEN;
            end else begin
              walk_phase_next = wfhp_pkg::PH_DONE;
            end
          end
        end
        wfhp_pkg::PH_LEN: begin
          if (CMP_W'(element_start) + CMP_W'(2) + CMP_W'(data_byte) > flen_ext) begin
            walk_phase_next = wfhp_pkg::PH_DONE;
          end else if (element_tag == 8'd0) begin
            if (data_byte == 8'd0) begin
              ssid_state_next = wfhp_pkg::SSID_HIDDEN;
              walk_phase_next = wfhp_pkg::PH_DONE;
            end else begin
              ssid_state_next        = wfhp_pkg::SSID_PRESENT;
              element_remaining_next = data_byte;
              walk_phase_next        = wfhp_pkg::PH_BODY;
            end
          end else if (data_byte == 8'd0) begin
            element_start_next = ES_W'(byte_position) + ES_W'(1);
            walk_phase_next    = wfhp_pkg::PH_TAG;
          end else begin
            element_remaining_next = data_byte;
            walk_phase_next        = wfhp_pkg::PH_BODY;
          end
        end
        wfhp_pkg::PH_BODY: begin
          if (element_tag == 8'd0 && ssid_count < CNT_W'(SSID_MAX_CHARS)) begin
            emit            = 1'b1;
            ch              = (data_byte < wfhp_pkg::CHAR_LOW || data_byte > wfhp_pkg::CHAR_HIGH)
                            ? wfhp_pkg::CHAR_DOT : data_byte;
            ssid_count_next = ssid_count + CNT_W'(1);
          end
          element_remaining_next = rem_dec;
          if (rem_dec == 8'd0) begin
            if (element_tag == 8'd0) begin
              walk_phase_next = wfhp_pkg::PH_DONE;
            end else begin
              element_start_next = ES_W'(byte_position) + ES_W'(1);
              walk_phase_next    = wfhp_pkg::PH_TAG;
            end
          end
        end
        default: begin
        end
      endcase

      // llc/snap header check, only when the frame is long enough to hold it
      if (flen_ext >= hdr_len + CMP_W'(wfhp_pkg::SNAP_SPAN)) begin
        if (p_ext == hdr_len && snap_match == wfhp_pkg::SNAP_IDLE &&
            data_byte == wfhp_pkg::LLC_SAP) begin
          snap_match_next = wfhp_pkg::SNAP_AA1;
        end else if (p_ext == hdr_len + CMP_W'(1) && snap_match == wfhp_pkg::SNAP_AA1 &&
                     data_byte == wfhp_pkg::LLC_SAP) begin
          snap_match_next = wfhp_pkg::SNAP_AA2;
        end else if (p_ext == hdr_len + CMP_W'(2) && snap_match == wfhp_pkg::SNAP_AA2 &&
                     data_byte == wfhp_pkg::LLC_CTRL_UI) begin
          snap_match_next = wfhp_pkg::SNAP_UI;
        end else if (p_ext == hdr_len + CMP_W'(6) && snap_match == wfhp_pkg::SNAP_UI) begin
          ether_word_next = {data_byte, 8'd0};
          snap_match_next = wfhp_pkg::SNAP_ET1;
        end else if (p_ext == hdr_len + CMP_W'(7) && snap_match == wfhp_pkg::SNAP_ET1) begin
          ether_word_next = {ether_word[15:8], data_byte};
          snap_match_next = wfhp_pkg::SNAP_DONE;
        end
      end
    end

    // position saturates at the frame size limit
    if (byte_position < POS_W'(MAX_FRAME_BYTES)) begin
      byte_position_next = byte_position + POS_W'(1);
    end

    // summary reflects this byte's updates
    keep    = !drop_flag_next;
    snap_ok = keep && (snap_match_next == wfhp_pkg::SNAP_DONE);

    char_item           = '0;
    char_item.ssid_char = ch;

    sum_item                     = '0;
    sum_item.is_summary          = 1'b1;
    sum_item.discarded           = drop_flag_next;
    sum_item.frame_type          = control_word_next[3:2];
    sum_item.frame_subtype       = control_word_next[7:4];
    sum_item.destination_address = keep ? dest_shift_next : 48'd0;
    sum_item.source_address      = keep ? src_shift_next : 48'd0;
    sum_item.dest_bcast          = keep && (dest_shift_next == {48{1'b1}});
    sum_item.ssid_status         = keep ? ssid_state_next : wfhp_pkg::SSID_NONE;
    sum_item.ssid_length         = keep ? 6'(ssid_count_next) : 6'd0;
    sum_item.ethertype           = snap_ok ? ether_word_next : 16'd0;
    sum_item.snap_found          = snap_ok;

    if (last_byte) begin
      byte_position_next     = '0;
      control_word_next      = '0;
      dest_shift_next        = '0;
      src_shift_next         = '0;
      element_start_next     = '0;
      element_tag_next       = '0;
      element_remaining_next = '0;
      walk_phase_next        = wfhp_pkg::PH_TAG;
      ssid_state_next        = wfhp_pkg::SSID_NONE;
      ssid_count_next        = '0;
      snap_match_next        = wfhp_pkg::SNAP_IDLE;
      ether_word_next        = '0;
      drop_flag_next         = 1'b0;
    end

    // character first, summary behind it
    push_a     = emit ? char_item : sum_item;
    push_b     = sum_item;
    push_count = 2'd0;
    if (accept) begin
      push_count = 2'(emit) + 2'(last_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      control_word      <= '0;
      dest_shift        <= '0;
      src_shift         <= '0;
      element_start     <= '0;
      element_tag       <= '0;
      element_remaining <= '0;
      walk_phase        <= wfhp_pkg::PH_TAG;
      ssid_state        <= wfhp_pkg::SSID_NONE;
      ssid_count        <= '0;
      snap_match        <= wfhp_pkg::SNAP_IDLE;
      ether_word        <= '0;
      drop_flag         <= 1'b0;
    end else if (accept) begin
      byte_position     <= byte_position_next;
      control_word      <= control_word_next;
      dest_shift        <= dest_shift_next;
      src_shift         <= src_shift_next;
      element_start     <= element_start_next;
      element_tag       <= element_tag_next;
      element_remaining <= element_remaining_next;
      walk_phase        <= walk_phase_next;
      ssid_state        <= ssid_state_next;
      ssid_count        <= ssid_count_next;
      snap_match        <= snap_match_next;
      ether_word        <= ether_word_next;
      drop_flag         <= drop_flag_next;
    end
  end

  wfhp_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_count   (push_count),
    .push_a       (push_a),
    .push_b       (push_b),
    .pop          (m_axis_tvalid & m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_item     (out_item),
    .room_for_two (room_for_two)
  );

  assign s_axis_tready = room_for_two;
  assign m_axis_tuser  = out_item.is_summary;
  assign m_axis_tdata  = {7'd0, out_item.snap_found, out_item.ethertype, out_item.ssid_length,
                          out_item.ssid_status, out_item.dest_bcast, out_item.source_address,
                          out_item.destination_address, out_item.frame_subtype,
                          out_item.frame_type, out_item.discarded, out_item.ssid_char};

endmodule
